### src/ckm_pkg.sv
package ckm_pkg;

	localparam int ROWS_DEF        = 5;
	localparam int COLS_DEF        = 8;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int THR_W     = 12;
	localparam int CHMAP_W   = 24;
	localparam logic [CHMAP_W-1:0] CHMAP_RESET = 24'hFAC688;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [0:0] REG_CHANNEL_MAP = 1'b0;

	typedef struct packed {
		logic       bank;
		logic [2:0] col;
		logic [2:0] row;
	} pos_t;

endpackage

### src/ckm_thr_mem.sv
module ckm_thr_mem #(
	parameter int ROWS          = ckm_pkg::ROWS_DEF,
	parameter int COLS_PER_BANK = ckm_pkg::COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  ckm_pkg::pos_t                wr_key,
	input  logic [ckm_pkg::THR_W-1:0]    wr_low,
	input  logic [ckm_pkg::THR_W-1:0]    wr_high,
	input  logic                         rd_en,
	input  ckm_pkg::pos_t                rd_key,
	output logic [ckm_pkg::THR_W-1:0]    rd_low,
	output logic [ckm_pkg::THR_W-1:0]    rd_high
);
	import ckm_pkg::*;

	localparam int KEYS_PER_ROW = 2 * COLS_PER_BANK;
	localparam int KEY_COUNT    = ROWS * KEYS_PER_ROW;
	localparam int KIDX_W       = $clog2(KEY_COUNT);

	function automatic logic [KIDX_W-1:0] key_index(input pos_t k);
		int unsigned v;
		v = int'(k.row) * KEYS_PER_ROW + int'(k.bank) * COLS_PER_BANK + int'(k.col);
		return v[KIDX_W-1:0];
	endfunction

	logic [2*THR_W-1:0]  mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] valid_q;
	logic [2*THR_W-1:0]  rd_data_q;
	logic                rd_valid_q;
	logic [KIDX_W-1:0]   wr_idx;
	logic [KIDX_W-1:0]   rd_idx;

	assign wr_idx = key_index(wr_key);
	assign rd_idx = key_index(rd_key);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_high, wr_low};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	// unwritten keys read as low zero, high all ones
	assign rd_low  = rd_valid_q ? rd_data_q[THR_W-1:0]       : '0;
	assign rd_high = rd_valid_q ? rd_data_q[2*THR_W-1:THR_W] : '1;

endmodule

### src/ckm_pos.sv
module ckm_pos #(
	parameter int ROWS          = ckm_pkg::ROWS_DEF,
	parameter int COLS_PER_BANK = ckm_pkg::COLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	output ckm_pkg::pos_t cur,
	output ckm_pkg::pos_t nxt,
	output logic          last
);
	import ckm_pkg::*;

	localparam logic [2:0] ROW_LAST = 3'(ROWS - 1);
	localparam logic [2:0] COL_LAST = 3'(COLS_PER_BANK - 1);

	pos_t pos_q;

	assign cur  = pos_q;
	assign last = pos_q.bank && (pos_q.col == COL_LAST) && (pos_q.row == ROW_LAST);

	always_comb begin
		nxt = pos_q;
		if (last) begin
			nxt = '0;
		end else if (pos_q.row != ROW_LAST) begin
			nxt.row = pos_q.row + 3'd1;
		end else begin
			nxt.row = '0;
			if (pos_q.col != COL_LAST) begin
				nxt.col = pos_q.col + 3'd1;
			end else begin
				nxt.col  = '0;
				nxt.bank = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv) begin
			pos_q <= nxt;
		end
	end

endmodule

### src/capacitive_key_matrix_hysteresis_scan_top.sv
// Capacitive key matrix scanner with per-key press/release hysteresis.
// Input stream (s_*): s_tuser is the command, 0 writes the thresholds of the
// key named in s_tdata, 1 delivers the ADC sample of the key at the current
// scan position. Write beats produce no output beat.
// Output stream (m_*): one beat per sample beat, giving the scanned key, its
// new state, a changed flag, the next mux bank, select and drive row; tlast
// marks the sample ending a full scan, whose beat carries the any-change flag.
// Throughput: one beat per cycle while m_tready stays high; the position
// counter and the registered threshold memory read load the sample stage,
// and one compare sits between it and the output register.
// When m_tready is low the output register holds, the sample stage holds
// behind it and s_tready drops once both are full.
// Reset clears the scan position, key states, change flag and the threshold
// valid bits (all keys released, unwritten keys cannot press) and loads the
// channel map with its default. The APB port writes the channel map with
// no wait states; write it only while the stream is idle.
module capacitive_key_matrix_hysteresis_scan_top #(
	parameter int ROWS          = ckm_pkg::ROWS_DEF,
	parameter int COLS_PER_BANK = ckm_pkg::COLS_DEF,
	parameter int SAMPLE_BITS   = ckm_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// key_row[2:0], key_col[6:3], low_threshold[18:7], high_threshold[30:19],
	// sample[42:31], zero fill
	input  logic [47:0] s_tdata,
	// cmd[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scanned_row[2:0], scanned_col[6:3], pressed[7], changed[8],
	// scan_updated[9], next_bank[10], next_mux_select[13:11],
	// next_drive_row[16:14], zero fill
	output logic [23:0] m_tdata,
	// scan_last
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ckm_pkg::*;

	localparam int         CMP_W           = (SAMPLE_BITS < THR_W) ? SAMPLE_BITS : THR_W;
	localparam int         ROW_IW          = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [CHMAP_W-1:0] channel_map_q;

	logic [2:0]       in_row;
	logic [3:0]       in_col;
	logic [THR_W-1:0] in_low;
	logic [THR_W-1:0] in_high;
	logic [THR_W-1:0] in_sample;
	logic             accept;
	logic             wr_en;
	logic             rd_en;
	pos_t             wr_key;

	pos_t             pos_cur;
	pos_t             pos_nxt;
	logic             pos_last;

	logic             v_s1;
	pos_t             pos_s1;
	pos_t             nxt_s1;
	logic             last_s1;
	logic [THR_W-1:0] sample_s1;
	logic [THR_W-1:0] low_s1;
	logic [THR_W-1:0] high_s1;
	logic             adv_s1;

	logic [15:0]      key_state_q [ROWS];
	logic             change_seen_q;
	logic [ROW_IW-1:0] row_idx;
	logic [3:0]       bitpos;
	logic             cur_st;
	logic             now_st;
	logic             chg;
	logic             upd;
	logic [2:0]       nxt_sel;

	logic             m_valid_q;
	logic [23:0]      m_data_q;
	logic             m_last_q;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_map_q <= CHMAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2:2] == REG_CHANNEL_MAP)) begin
			channel_map_q <= pwdata[CHMAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:2] == REG_CHANNEL_MAP) begin
			prdata = {{(32-CHMAP_W){1'b0}}, channel_map_q};
		end
	end

	// input beat
	assign in_row    = s_tdata[2:0];
	assign in_col    = s_tdata[6:3];
	assign in_low    = s_tdata[18:7];
	assign in_high   = s_tdata[30:19];
	assign in_sample = s_tdata[42:31];

	assign s_tready = !v_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;
	assign rd_en    = accept && (s_tuser == CMD_SAMPLE);
	assign wr_en    = accept && (s_tuser == CMD_WRITE)
		&& (int'(in_row) < ROWS) && (int'(in_col[2:0]) < COLS_PER_BANK);

	assign wr_key = '{bank: in_col[3], col: in_col[2:0], row: in_row};

	ckm_pos #(
		.ROWS          (ROWS),
		.COLS_PER_BANK (COLS_PER_BANK)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (rd_en),
		.cur    (pos_cur),
		.nxt    (pos_nxt),
		.last   (pos_last)
	);

	ckm_thr_mem #(
		.ROWS          (ROWS),
		.COLS_PER_BANK (COLS_PER_BANK)
	) u_thr_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_key  (wr_key),
		.wr_low  (in_low),
		.wr_high (in_high),
		.rd_en   (rd_en),
		.rd_key  (pos_cur),
		.rd_low  (low_s1),
		.rd_high (high_s1)
	);

	// sample stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rd_en) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pos_s1    <= pos_cur;
			nxt_s1    <= pos_nxt;
			last_s1   <= pos_last;
			sample_s1 <= in_sample;
		end
	end

	assign adv_s1  = v_s1 && (!m_valid_q || m_tready);
	assign row_idx = pos_s1.row[ROW_IW-1:0];
	assign bitpos  = {pos_s1.bank, pos_s1.col};
	assign cur_st  = key_state_q[row_idx][bitpos];

	always_comb begin
		now_st = cur_st;
		if (cur_st && (sample_s1[CMP_W-1:0] < low_s1[CMP_W-1:0])) begin
			now_st = 1'b0;
		end else if (!cur_st && (sample_s1[CMP_W-1:0] > high_s1[CMP_W-1:0])) begin
			now_st = 1'b1;
		end
	end

	assign chg     = now_st ^ cur_st;
	assign upd     = last_s1 && (change_seen_q || chg);
	assign nxt_sel = 3'(channel_map_q >> (5'(nxt_s1.col) * 5'd3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				key_state_q[r] <= '0;
			end
			change_seen_q <= 1'b0;
		end else if (adv_s1) begin
			key_state_q[row_idx][bitpos] <= now_st;
			change_seen_q <= last_s1 ? 1'b0 : (change_seen_q || chg);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_data_q <= {7'b0, nxt_s1.row, nxt_sel, nxt_s1.bank, upd, chg, now_st,
				pos_s1.bank, pos_s1.col, pos_s1.row};
			m_last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_wrap_to_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[10] == 1'b0) && (m_tdata[16:14] == 3'd0))
		else $error("scan end does not wrap to origin");

	a_upd_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[9] == 1'b0))
		else $error("scan_updated outside scan end");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(pos_s1) && $stable(sample_s1))
		else $error("sample stage lost a held beat");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	a_changed_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && chg |-> (now_st != cur_st))
		else $error("changed flag without a state flip");
`endif

endmodule

### bench/capacitive_key_matrix_hysteresis_scan_top_tb.sv
module capacitive_key_matrix_hysteresis_scan_top_tb;
	import ckm_pkg::*;

	localparam int KEYS_PER_ROW = 2 * COLS_DEF;
	localparam int KEY_COUNT = ROWS_DEF * KEYS_PER_ROW;
	localparam logic [THR_W-1:0] SAMPLE_MASK = THR_W'((1 << SAMPLE_BITS_DEF) - 1);
	localparam logic [2:0] ADDR_CHANNEL_MAP = {REG_CHANNEL_MAP, 2'b00};
	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [2:0] row;
		logic [3:0] col;
		logic       pressed;
		logic       changed;
		logic       scan_last;
		logic       scan_updated;
		logic       next_bank;
		logic [2:0] next_sel;
		logic [2:0] next_row;
	} key_report_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [THR_W-1:0]   low_thr [KEY_COUNT];
	logic [THR_W-1:0]   high_thr [KEY_COUNT];
	logic [15:0]        key_bits [ROWS_DEF];
	logic               pos_bank;
	logic [2:0]         pos_col;
	logic [2:0]         pos_row;
	logic               seen_change;
	logic [CHMAP_W-1:0] chan_map;

	key_report_t due_reports [$];
	int fail_count = 0;
	int cycle_count = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;
	int rx_hold = 0;

	capacitive_key_matrix_hysteresis_scan_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	function automatic void apply_key_beat(logic cmd, logic [2:0] krow, logic [3:0] kcol,
			logic [THR_W-1:0] lo, logic [THR_W-1:0] hi, logic [THR_W-1:0] smp);
		int idx;
		int bitpos;
		logic cur;
		logic now;
		key_report_t rep;
		if (cmd == CMD_WRITE) begin
			if (krow < ROWS_DEF && kcol[2:0] < COLS_DEF) begin
				idx = krow * KEYS_PER_ROW + kcol[3] * COLS_DEF + kcol[2:0];
				low_thr[idx] = lo;
				high_thr[idx] = hi;
			end
			return;
		end
		idx = pos_row * KEYS_PER_ROW + pos_bank * COLS_DEF + pos_col;
		bitpos = pos_bank * 8 + pos_col;
		cur = key_bits[pos_row][bitpos];
		now = cur;
		if (cur && (smp & SAMPLE_MASK) < (low_thr[idx] & SAMPLE_MASK))
			now = 1'b0;
		else if (!cur && (smp & SAMPLE_MASK) > (high_thr[idx] & SAMPLE_MASK))
			now = 1'b1;
		key_bits[pos_row][bitpos] = now;
		rep.row = pos_row;
		rep.col = 4'(bitpos);
		rep.pressed = now;
		rep.changed = now ^ cur;
		rep.scan_last = pos_bank && pos_col == COLS_DEF - 1 && pos_row == ROWS_DEF - 1;
		rep.scan_updated = 1'b0;
		if (rep.scan_last) begin
			rep.scan_updated = seen_change | rep.changed;
			seen_change = 1'b0;
			pos_bank = 1'b0;
			pos_col = 3'd0;
			pos_row = 3'd0;
		end else begin
			seen_change = seen_change | rep.changed;
			if (pos_row + 1 < ROWS_DEF) begin
				pos_row = pos_row + 3'd1;
			end else begin
				pos_row = 3'd0;
				if (pos_col + 1 < COLS_DEF) begin
					pos_col = pos_col + 3'd1;
				end else begin
					pos_col = 3'd0;
					pos_bank = 1'b1;
				end
			end
		end
		rep.next_bank = pos_bank;
		rep.next_sel = chan_map[3 * pos_col +: 3];
		rep.next_row = pos_row;
		due_reports.push_back(rep);
	endfunction

	function automatic logic [THR_W-1:0] pick_sample();
		int idx;
		int lo;
		int hi;
		idx = pos_row * KEYS_PER_ROW + pos_bank * COLS_DEF + pos_col;
		lo = low_thr[idx];
		hi = high_thr[idx];
		case ($urandom_range(0, 6))
			0: return THR_W'(lo == 0 ? 0 : lo - 1);
			1: return THR_W'(lo);
			2: return THR_W'(hi);
			3: return THR_W'(hi == 4095 ? 4095 : hi + 1);
			4: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			default: return THR_W'($urandom_range(0, 4095));
		endcase
	endfunction

	always @(posedge clk) begin
		key_report_t want;
		key_report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[2:0];
			got.col = m_tdata[6:3];
			got.pressed = m_tdata[7];
			got.changed = m_tdata[8];
			got.scan_updated = m_tdata[9];
			got.next_bank = m_tdata[10];
			got.next_sel = m_tdata[13:11];
			got.next_row = m_tdata[16:14];
			got.scan_last = m_tlast;
			if (due_reports.size() == 0) begin
				$display("%0t unexpected beat: expected none, got %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = due_reports.pop_front();
				check_field("scanned_row", want.row, got.row);
				check_field("scanned_col", want.col, got.col);
				check_field("pressed", want.pressed, got.pressed);
				check_field("changed", want.changed, got.changed);
				check_field("scan_last", want.scan_last, got.scan_last);
				check_field("scan_updated", want.scan_updated, got.scan_updated);
				check_field("next_bank", want.next_bank, got.next_bank);
				check_field("next_mux_select", want.next_sel, got.next_sel);
				check_field("next_drive_row", want.next_row, got.next_row);
			end
		end
	end

	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = rx_stalls ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_beat(logic cmd, logic [2:0] krow, logic [3:0] kcol,
			logic [THR_W-1:0] lo, logic [THR_W-1:0] hi, logic [THR_W-1:0] smp);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, smp, hi, lo, kcol, krow};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_key_beat(cmd, krow, kcol, lo, hi, smp);
	endtask

	task automatic send_sample(logic [THR_W-1:0] smp);
		send_beat(CMD_SAMPLE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
			THR_W'($urandom_range(0, 4095)), THR_W'($urandom_range(0, 4095)), smp);
	endtask

	task automatic send_threshold(logic [2:0] krow, logic [3:0] kcol);
		logic [THR_W-1:0] a;
		logic [THR_W-1:0] b;
		a = THR_W'($urandom_range(0, 4095));
		b = THR_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 3) != 0 && a > b)
			send_beat(CMD_WRITE, krow, kcol, b, a, THR_W'($urandom_range(0, 4095)));
		else
			send_beat(CMD_WRITE, krow, kcol, a, b, THR_W'($urandom_range(0, 4095)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_channel_map(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CHANNEL_MAP;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		chan_map = value[CHMAP_W-1:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("channel_map readback", chan_map, prdata[CHMAP_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		int i;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		send_beat(CMD_WRITE, 3'd0, 4'd0, 12'h000, 12'h000, 12'h000);
		send_beat(CMD_WRITE, 3'd4, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF);
		send_beat(CMD_WRITE, 3'd1, 4'd0, 12'hFFF, 12'h000, 12'h000);
		send_beat(CMD_WRITE, 3'd7, 4'd15, 12'h000, 12'h000, 12'hFFF);
		send_beat(CMD_WRITE, 3'd5, 4'd8, 12'h555, 12'hAAA, 12'h000);
		send_beat(CMD_SAMPLE, 3'd7, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF);
		send_beat(CMD_SAMPLE, 3'd0, 4'd0, 12'h000, 12'h000, 12'h000);
		send_beat(CMD_SAMPLE, 3'd0, 4'd0, 12'h000, 12'h000, 12'hFFF);
		send_beat(CMD_WRITE, 3'd3, 4'd0, 12'h800, 12'h7FF, 12'h000);
		send_beat(CMD_SAMPLE, 3'd0, 4'd0, 12'h000, 12'h000, 12'h800);
		send_beat(CMD_SAMPLE, 3'd0, 4'd0, 12'h000, 12'h000, 12'hFFF);
		for (i = 0; i < 12; i++)
			send_sample(pick_sample());
		wait_idle();
	endtask

	task automatic test_threshold_load();
		int r;
		int c;
		tx_gaps = 1'b0;
		rx_stalls = 1'b1;
		for (r = 0; r < ROWS_DEF; r++)
			for (c = 0; c < KEYS_PER_ROW; c++)
				send_threshold(3'(r), 4'(c));
		for (c = 0; c < 20; c++)
			send_sample(pick_sample());
		wait_idle();
	endtask

	task automatic test_backpressure();
		int i;
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		rx_hold = 120;
		for (i = 0; i < 60; i++)
			send_sample(pick_sample());
		wait_idle();
	endtask

	task automatic test_random_scan();
		logic [CHMAP_W-1:0] maps [5];
		int p;
		int i;
		int r;
		maps[0] = '0;
		maps[1] = '1;
		maps[2] = CHMAP_W'($urandom);
		maps[3] = CHMAP_W'($urandom);
		maps[4] = CHMAP_RESET;
		for (p = 0; p < 5; p++) begin
			wait_idle();
			write_channel_map({8'($urandom), maps[p]});
			for (i = 0; i < 220; i++) begin
				if (i % 50 == 0) begin
					tx_gaps = (p != 0) && $urandom_range(0, 1);
					rx_stalls = (p != 0) && $urandom_range(0, 1);
				end
				if (i == 110)
					wait_idle();
				r = $urandom_range(0, 99);
				if (r < 18)
					send_threshold(3'($urandom_range(0, ROWS_DEF - 1)),
						4'($urandom_range(0, 15)));
				else if (r < 22)
					send_threshold(3'($urandom_range(ROWS_DEF, 7)), 4'($urandom_range(0, 15)));
				else
					send_sample(pick_sample());
			end
		end
		wait_idle();
	endtask

	initial begin
		int i;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_WRITE;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_CHANNEL_MAP;
		pwdata <= '0;
		arst_n <= 1'b0;
		for (i = 0; i < KEY_COUNT; i++) begin
			low_thr[i] = '0;
			high_thr[i] = '1;
		end
		for (i = 0; i < ROWS_DEF; i++)
			key_bits[i] = '0;
		pos_bank = 1'b0;
		pos_col = 3'd0;
		pos_row = 3'd0;
		seen_change = 1'b0;
		chan_map = CHMAP_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_load();
		test_backpressure();
		test_random_scan();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
